// ===== hdl/drc_pkg.sv =====
// Shared types, constants and lookup tables for the dynamic range compressor.
// No dependencies; the front end, back end and top level refer to it by scoped names.
package drc_pkg;

    localparam int LEVEL_W = 17;
    localparam int THR_W   = 16;
    localparam int RATIO_W = 15;
    localparam int GAIN_W  = 17;

    localparam logic [15:0]        DECAY_Q16       = 16'd65208;
    localparam logic [18:0]        DB_PER_LOG2     = 19'd394566;
    localparam logic [21:0]        LOG2_PER_DB256  = 22'd2786634;
    localparam logic [16:0]        DB_FLOOR_MAG    = 17'd46080;
    localparam logic [RATIO_W-1:0] RATIO_MIN       = 15'd256;
    localparam logic [THR_W-1:0]   THR_RESET       = 16'hEE00;
    localparam logic [RATIO_W-1:0] RATIO_RESET     = 15'd1024;
    localparam logic [GAIN_W-1:0]  GAIN_UNITY      = 17'd65536;

    localparam logic ADDR_THRESHOLD = 1'b0;
    localparam logic ADDR_RATIO     = 1'b1;

    typedef enum logic [2:0] {
        F_IDLE, F_ENV, F_NORM, F_LOG, F_DB, F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE, B_OVER, B_DIV, B_EXP, B_GAIN, B_MUL
    } back_state_t;

    // log2(1 + i/16) in Q16.
    function automatic logic [16:0] log2_tab(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd5732;
            5'd2:    v = 17'd11136;
            5'd3:    v = 17'd16248;
            5'd4:    v = 17'd21098;
            5'd5:    v = 17'd25711;
            5'd6:    v = 17'd30109;
            5'd7:    v = 17'd34312;
            5'd8:    v = 17'd38336;
            5'd9:    v = 17'd42196;
            5'd10:   v = 17'd45904;
            5'd11:   v = 17'd49472;
            5'd12:   v = 17'd52911;
            5'd13:   v = 17'd56229;
            5'd14:   v = 17'd59434;
            5'd15:   v = 17'd62534;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // 2^(-i/16) in Q16.
    function automatic logic [16:0] exp2_tab(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/drc_front.sv =====
// Front end: accepts samples, updates the peak envelope and converts it to a dB level.
// Uses drc_pkg for tables and state type; feeds drc_queue.
module drc_front #(
    parameter int SB = 24
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [SB-1:0]                    in_sample,
    input  logic                             in_last,
    output logic                             q_valid,
    input  logic                             q_ready,
    output logic [SB-1:0]                    q_sample,
    output logic                             q_last,
    output logic signed [drc_pkg::LEVEL_W-1:0] q_level
);
    localparam int SHW  = $clog2(SB);
    localparam int NLW  = SHW + 16;
    localparam int DBW  = NLW + 20;

    drc_pkg::front_state_t state_reg, state_next;
    logic [SB-1:0]  sample_reg, env_reg, env_next, norm_reg, norm_next;
    logic           last_reg;
    logic [SHW-1:0] sh_reg, sh_next;
    logic [NLW-1:0] neglog_reg, neglog_next;
    logic signed [drc_pkg::LEVEL_W-1:0] lvl_reg, lvl_next;

    logic [SB-1:0]    mag, decayed;
    logic [SB+15:0]   decay_prod;
    logic [SB+14:0]   ext;
    logic [15:0]      frac;
    logic [16:0]      t0, t1, lf;
    logic [28:0]      slope;
    logic [DBW-1:0]   db_sum, dbm;

    assign mag        = sample_reg[SB-1] ? (~sample_reg + 1'b1) : sample_reg;
    assign decay_prod = env_reg * drc_pkg::DECAY_Q16;
    assign decayed    = decay_prod[SB+15:16];

    // The 16 bits below the leading one of the normalized envelope.
    assign ext   = {norm_reg[SB-2:0], 16'b0};
    assign frac  = ext[SB+14 -: 16];
    assign t0    = drc_pkg::log2_tab({1'b0, frac[15:12]});
    assign t1    = drc_pkg::log2_tab({1'b0, frac[15:12]} + 5'd1);
    assign slope = (t1 - t0) * frac[11:0];
    assign lf    = t0 + slope[28:12];

    assign db_sum = neglog_reg * drc_pkg::DB_PER_LOG2 + (DBW'(1) << 23);
    assign dbm    = db_sum >> 24;

    assign in_ready = (state_reg == drc_pkg::F_IDLE);
    assign q_valid  = (state_reg == drc_pkg::F_PUSH);
    assign q_sample = sample_reg;
    assign q_last   = last_reg;
    assign q_level  = lvl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= drc_pkg::F_IDLE;
            env_reg   <= '0;
        end else begin
            state_reg <= state_next;
            env_reg   <= env_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sample_reg <= in_sample;
            last_reg   <= in_last;
        end
        norm_reg   <= norm_next;
        sh_reg     <= sh_next;
        neglog_reg <= neglog_next;
        lvl_reg    <= lvl_next;
    end

    always_comb begin
        state_next  = state_reg;
        env_next    = env_reg;
        norm_next   = norm_reg;
        sh_next     = sh_reg;
        neglog_next = neglog_reg;
        lvl_next    = lvl_reg;
        unique case (state_reg)
            drc_pkg::F_IDLE: begin
                if (in_valid) state_next = drc_pkg::F_ENV;
            end
            drc_pkg::F_ENV: begin
                env_next  = (mag > decayed) ? mag : decayed;
                norm_next = env_next;
                sh_next   = '0;
                if (env_next == '0) begin
                    lvl_next   = -$signed({1'b0, drc_pkg::DB_FLOOR_MAG[15:0]});
                    state_next = drc_pkg::F_PUSH;
                end else begin
                    state_next = drc_pkg::F_NORM;
                end
            end
            drc_pkg::F_NORM: begin
                // One bit of normalization per cycle until the leading one is on top.
                if (norm_reg[SB-1]) begin
                    state_next = drc_pkg::F_LOG;
                end else begin
                    norm_next = norm_reg << 1;
                    sh_next   = sh_reg + 1'b1;
                end
            end
            drc_pkg::F_LOG: begin
                neglog_next = {sh_reg, 16'b0} - NLW'(lf);
                state_next  = drc_pkg::F_DB;
            end
            drc_pkg::F_DB: begin
                if (dbm > DBW'(drc_pkg::DB_FLOOR_MAG))
                    lvl_next = -$signed({1'b0, drc_pkg::DB_FLOOR_MAG[15:0]});
                else
                    lvl_next = -$signed(dbm[drc_pkg::LEVEL_W-1:0]);
                state_next = drc_pkg::F_PUSH;
            end
            drc_pkg::F_PUSH: begin
                if (q_ready) state_next = drc_pkg::F_IDLE;
            end
            default: state_next = drc_pkg::F_IDLE;
        endcase
    end

endmodule

// ===== hdl/drc_queue.sv =====
// Two-entry queue between the front and back ends of the compressor.
// Generic width; no package dependencies.
module drc_queue #(
    parameter int W = 42
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (do_wr) wp_reg <= ~wp_reg;
            if (do_rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) mem_reg[wp_reg] <= wr_data;
    end

endmodule

// ===== hdl/drc_back.sv =====
// Back end: gain reduction, divide by ratio, exponential gain and output multiply.
// Uses drc_pkg for tables and state type; reads from drc_queue.
module drc_back #(
    parameter int SB = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  logic [SB-1:0]                       q_sample,
    input  logic                                q_last,
    input  logic signed [drc_pkg::LEVEL_W-1:0]  q_level,
    input  logic [drc_pkg::THR_W-1:0]           threshold,
    input  logic [drc_pkg::RATIO_W-1:0]         ratio,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [SB-1:0]                       out_sample,
    output logic                                out_last
);
    drc_pkg::back_state_t state_reg, state_next;
    logic [SB-1:0]  sample_reg, osample_reg;
    logic           last_reg, olast_reg, ovalid_reg;
    logic signed [drc_pkg::LEVEL_W-1:0] lvl_reg;
    logic [31:0]    num_reg;
    logic [15:0]    rem_reg;
    logic [4:0]     cnt_reg;
    logic [23:0]    e_reg;
    logic [drc_pkg::GAIN_W-1:0] g_reg;

    logic [SB-1:0]  mag, m;
    logic [SB+16:0] mprod;
    logic signed [17:0] diff;
    logic [16:0]    over;
    logic [15:0]    trial;
    logic           qbit;
    logic [39:0]    e_sum;
    logic [16:0]    t0, t1, g_int;
    logic [28:0]    slope;

    assign mag   = sample_reg[SB-1] ? (~sample_reg + 1'b1) : sample_reg;
    assign diff  = 18'(lvl_reg) - 18'($signed(threshold));
    assign over  = diff[16:0];
    assign trial = {rem_reg[14:0], num_reg[31]};
    assign qbit  = (trial >= {1'b0, ratio});
    assign e_sum = num_reg[16:0] * drc_pkg::LOG2_PER_DB256 + 40'd32768;
    assign t0    = drc_pkg::exp2_tab({1'b0, e_reg[15:12]});
    assign t1    = drc_pkg::exp2_tab({1'b0, e_reg[15:12]} + 5'd1);
    assign slope = (t0 - t1) * e_reg[11:0];
    assign g_int = t0 - slope[28:12];
    assign mprod = mag * g_reg;
    assign m     = mprod[SB+15:16];

    assign q_ready    = (state_reg == drc_pkg::B_IDLE);
    assign out_valid  = ovalid_reg;
    assign out_sample = osample_reg;
    assign out_last   = olast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= drc_pkg::B_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == drc_pkg::B_MUL && (!ovalid_reg || out_ready))
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            drc_pkg::B_IDLE: begin
                sample_reg <= q_sample;
                last_reg   <= q_last;
                lvl_reg    <= q_level;
                g_reg      <= drc_pkg::GAIN_UNITY;
            end
            drc_pkg::B_OVER: begin
                num_reg <= over * (ratio - drc_pkg::RATIO_MIN);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            drc_pkg::B_DIV: begin
                // Restoring division, one quotient bit per cycle.
                rem_reg <= qbit ? (trial - {1'b0, ratio}) : trial;
                num_reg <= {num_reg[30:0], qbit};
                cnt_reg <= cnt_reg + 1'b1;
            end
            drc_pkg::B_EXP: e_reg <= e_sum[39:16];
            drc_pkg::B_GAIN: begin
                if (e_reg[23:16] >= 8'd32) g_reg <= '0;
                else g_reg <= g_int >> e_reg[20:16];
            end
            drc_pkg::B_MUL: begin
                if (!ovalid_reg || out_ready) begin
                    osample_reg <= sample_reg[SB-1] ? (~m + 1'b1) : m;
                    olast_reg   <= last_reg;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            drc_pkg::B_IDLE: if (q_valid) state_next = drc_pkg::B_OVER;
            drc_pkg::B_OVER: begin
                // At or below the threshold the gain stays at unity.
                if (diff > 18'sd0) state_next = drc_pkg::B_DIV;
                else state_next = drc_pkg::B_MUL;
            end
            drc_pkg::B_DIV:  if (cnt_reg == 5'd31) state_next = drc_pkg::B_EXP;
            drc_pkg::B_EXP:  state_next = drc_pkg::B_GAIN;
            drc_pkg::B_GAIN: state_next = drc_pkg::B_MUL;
            drc_pkg::B_MUL:  if (!ovalid_reg || out_ready) state_next = drc_pkg::B_IDLE;
            default:         state_next = drc_pkg::B_IDLE;
        endcase
    end

endmodule

// ===== hdl/dynamic_range_compressor.sv =====
// Top level of the hard-knee peak compressor: configuration registers and block wiring.
// Depends on drc_pkg, drc_front, drc_queue and drc_back.
//
// One sample word goes in on the s_ side and one compressed word comes out on the m_ side,
// with tlast copied through. The front end passes on the floor level for a zero peak
// envelope, and otherwise shifts it left once per leading zero (up to SAMPLE_BITS-1),
// takes the log and converts it to dB. The back end goes straight to the output multiply
// at or below the threshold, and otherwise first runs the 32-step divide by the ratio,
// the exponential and the gain. A two-word queue lets the two ends overlap, so the
// sustained rate is that of the slower end while m_tready stays high. Registers: threshold
// at byte 0 (signed Q8.8 dB), ratio at byte 4 (unsigned Q7.8, writes below 1.0 read back as 1.0).
module dynamic_range_compressor #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // sample_in
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,  // sample_out
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int QW  = SAMPLE_BITS + 1 + drc_pkg::LEVEL_W;

    logic [drc_pkg::THR_W-1:0]   thr_reg;
    logic [drc_pkg::RATIO_W-1:0] ratio_reg;

    logic                                fq_valid, fq_ready, bq_valid, bq_ready;
    logic [SAMPLE_BITS-1:0]              f_sample, b_sample, o_sample;
    logic                                f_last, b_last;
    logic signed [drc_pkg::LEVEL_W-1:0]  f_level, b_level;
    logic [QW-1:0]                       bq_data;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {17'b0, ratio_reg} : {16'b0, thr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= drc_pkg::THR_RESET;
            ratio_reg <= drc_pkg::RATIO_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                drc_pkg::ADDR_THRESHOLD: thr_reg <= pwdata[15:0];
                drc_pkg::ADDR_RATIO: begin
                    if (pwdata[14:0] < drc_pkg::RATIO_MIN) ratio_reg <= drc_pkg::RATIO_MIN;
                    else ratio_reg <= pwdata[14:0];
                end
                default: ;
            endcase
        end
    end

    drc_front #(.SB(SAMPLE_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata[SAMPLE_BITS-1:0]),
        .in_last   (s_tlast),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_sample  (f_sample),
        .q_last    (f_last),
        .q_level   (f_level)
    );

    drc_queue #(.W(QW)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  ({f_level, f_last, f_sample}),
        .rd_valid (bq_valid),
        .rd_ready (bq_ready),
        .rd_data  (bq_data)
    );

    assign b_sample = bq_data[SAMPLE_BITS-1:0];
    assign b_last   = bq_data[SAMPLE_BITS];
    assign b_level  = $signed(bq_data[QW-1 -: drc_pkg::LEVEL_W]);

    drc_back #(.SB(SAMPLE_BITS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (bq_valid),
        .q_ready    (bq_ready),
        .q_sample   (b_sample),
        .q_last     (b_last),
        .q_level    (b_level),
        .threshold  (thr_reg),
        .ratio      (ratio_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (o_sample),
        .out_last   (m_tlast)
    );

    assign m_tdata = TDW'(o_sample);

endmodule

// ===== tb/sv/dynamic_range_compressor_test.sv =====
// Self-checking testbench for the hard-knee peak compressor.
// Drives sample words and register writes, predicts each compressed word and
// compares it with the m_ side. Depends on dynamic_range_compressor.
module dynamic_range_compressor_test;

    localparam int SB = 24;
    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_RATIO     = 3'd4;

    typedef struct packed {
        logic [SB-1:0] sample;
        logic          last;
    } word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [SB-1:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [SB-1:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    dynamic_range_compressor #(.SAMPLE_BITS(SB)) dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    word_t  pending_words[$];
    word_t  expected_words[$];
    int     errors = 0;
    int     cycles = 0;
    bit     quiet = 1'b0;
    bit     hold_send = 1'b0;
    int     send_gap = 0;
    int     recv_gap = 0;
    word_t  in_flight;
    logic   s_tready_q = 1'b0;

    // Predictor state.
    logic signed [15:0] thr_model;
    logic [14:0]        ratio_model;
    logic [63:0]        env_model;

    function automatic int unsigned log2_q16(int i);
        int unsigned t[17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
            42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
        return t[i];
    endfunction

    function automatic int unsigned exp2_q16(int i);
        int unsigned t[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
            46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
        return t[i];
    endfunction

    function automatic longint level_db256(logic [63:0] env);
        int p;
        logic [63:0] frac, lf, neglog, dbm;
        int idx, rem;
        longint lvl;
        if (env == 0) return -46080;
        p = 0;
        while (p < 40 && (env >> (p + 1)) != 0) p++;
        frac = ((env - (64'd1 << p)) << 16) >> p;
        idx = int'(frac >> 12) & 15;
        rem = int'(frac & 4095);
        lf = log2_q16(idx) + ((64'(log2_q16(idx + 1) - log2_q16(idx)) * rem) >> 12);
        neglog = (p >= SB - 1) ? 64'd0 : ((64'(SB - 1 - p) << 16) - lf);
        dbm = (neglog * 64'd394566 + (64'd1 << 23)) >> 24;
        lvl = -longint'(dbm);
        if (lvl < -46080) lvl = -46080;
        return lvl;
    endfunction

    function automatic logic [63:0] gain_q16(logic [63:0] red);
        logic [63:0] e, n, g;
        int f, idx, rem;
        e = (red * 64'd2786634 + 64'd32768) >> 16;
        n = e >> 16;
        f = int'(e & 64'hFFFF);
        idx = (f >> 12) & 15;
        rem = f & 4095;
        g = exp2_q16(idx) - ((64'(exp2_q16(idx) - exp2_q16(idx + 1)) * rem) >> 12);
        if (n >= 32) return 64'd0;
        return g >> n;
    endfunction

    function automatic word_t compress(word_t w);
        word_t r;
        logic neg;
        logic [63:0] mag, decayed, g, m, over, red;
        longint lvl;
        neg = w.sample[SB-1];
        mag = 64'(neg ? SB'(-w.sample) : w.sample);
        if (neg && w.sample == {1'b1, {(SB-1){1'b0}}}) mag = 64'd1 << (SB - 1);
        decayed = (env_model * 64'd65208) >> 16;
        env_model = (mag > decayed) ? mag : decayed;
        lvl = level_db256(env_model);
        g = 64'd65536;
        if (lvl > longint'(thr_model)) begin
            over = 64'(lvl - longint'(thr_model));
            red = (over * 64'(ratio_model - 15'd256)) / 64'(ratio_model);
            g = gain_q16(red);
        end
        m = (mag * g) >> 16;
        r.sample = neg ? SB'(-m) : SB'(m);
        r.last = w.last;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch: %s got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // Driver: words leave the queue at the falling edge.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready_q) begin
                expected_words.push_back(compress(in_flight));
            end
            if (!s_tvalid || s_tready_q) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (!hold_send && pending_words.size() > 0) begin
                    in_flight = pending_words.pop_front();
                    s_tdata <= in_flight.sample;
                    s_tlast <= in_flight.last;
                    s_tvalid <= 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 14);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 14);
            end
        end
    end

    // Monitor: handshakes are seen at the rising edge.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        s_tready_q <= s_tready && s_tvalid;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, 0);
            end else begin
                word_t want;
                want = expected_words.pop_front();
                if (m_tdata !== want.sample) report_mismatch("sample", m_tdata, want.sample);
                if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
            end
        end
        if (cycles > 2000000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_tvalid || expected_words.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == REG_THRESHOLD) thr_model = value[15:0];
        else if (addr == REG_RATIO)
            ratio_model = (value[14:0] < 15'd256) ? 15'd256 : value[14:0];
    endtask

    function automatic logic [SB-1:0] random_sample(int scale);
        logic [SB-1:0] v;
        v = SB'($urandom);
        return SB'($signed(v) >>> scale);
    endfunction

    task automatic queue_random(int count);
        word_t w;
        int scale;
        for (int i = 0; i < count; i++) begin
            scale = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SB - 1) : 0;
            w.sample = random_sample(scale);
            w.last = ($urandom_range(0, 7) == 0);
            pending_words.push_back(w);
        end
    endtask

    initial begin
        word_t w;
        thr_model = 16'shEE00;
        ratio_model = 15'd1024;
        env_model = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, silence, and the most negative sample.
        w.last = 1'b0; w.sample = '0;                     pending_words.push_back(w);
        w.sample = {1'b0, {(SB-1){1'b1}}};                pending_words.push_back(w);
        w.sample = {1'b1, {(SB-1){1'b0}}};                pending_words.push_back(w);
        w.last = 1'b1; w.sample = SB'(-1);                pending_words.push_back(w);
        w.last = 1'b0; w.sample = SB'(1);                 pending_words.push_back(w);
        for (int i = 0; i < 6; i++) begin
            w.sample = '0; w.last = (i == 5);
            pending_words.push_back(w);
        end
        wait_drained();

        // Ratio below 1.0, then threshold above 0 dB.
        write_reg(REG_RATIO, 32'd5);
        w.sample = {1'b0, {(SB-1){1'b1}}}; w.last = 1'b1; pending_words.push_back(w);
        wait_drained();
        write_reg(REG_THRESHOLD, 32'h0000_0100);
        write_reg(REG_RATIO, 32'h7FFF);
        w.sample = {1'b1, {(SB-1){1'b0}}}; pending_words.push_back(w);
        wait_drained();

        // Random phases across register settings, extremes included.
        write_reg(REG_THRESHOLD, 32'(-24576)); write_reg(REG_RATIO, 32'd16384);
        queue_random(200); wait_drained();
        write_reg(REG_THRESHOLD, 32'd0); write_reg(REG_RATIO, 32'd256);
        queue_random(150);
        // Halfway through, the sender waits until every expected word has come back.
        while (pending_words.size() > 75) @(posedge aclk);
        hold_send = 1'b1;
        while (s_tvalid || expected_words.size() > 0) @(posedge aclk);
        hold_send = 1'b0;
        wait_drained();
        write_reg(REG_THRESHOLD, 32'($urandom_range(0, 24576)) * -1);
        write_reg(REG_RATIO, $urandom_range(256, 16384));
        queue_random(250); wait_drained();
        write_reg(REG_THRESHOLD, 32'hFFFF_9FFF & 32'h0000_FFFF);
        write_reg(REG_RATIO, 32'hFFFF_8000 | $urandom_range(0, 32767));
        queue_random(250); wait_drained();
        quiet = 1'b1;
        write_reg(REG_THRESHOLD, 32'(-4608)); write_reg(REG_RATIO, 32'd1024);
        queue_random(250);
        wait_drained();

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/drc_pkg.sv
hdl/drc_front.sv
hdl/drc_queue.sv
hdl/drc_back.sv
hdl/dynamic_range_compressor.sv
tb/sv/dynamic_range_compressor_test.sv
